// ===== sv/oaids_pkg.sv =====
package oaids_pkg;

	// Built depth of the entry store and the widths that follow from it.
	localparam int DEPTH  = 256;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	// Fixed field widths of the beats.
	localparam int MODE_W = 2;
	localparam int POS_W  = 8;
	localparam int DATA_W = 32;
	localparam int CAP_W  = 9;
	localparam int STAT_W = 2;
	localparam int FILL_W = 9;

	// Working width for counts, positions and the capacity limit.
	localparam int WW = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	// Signed index width used by the binary search bounds.
	localparam int SW = WW + 1;
	// Operand width of the shared comparator.
	localparam int CW = DATA_W + 1;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

	// Operation codes.
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

	// Status codes.
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0]        mode;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] item_value;
		logic [POS_W-1:0]         range_low;
		logic [POS_W-1:0]         range_high;
	} in_item_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              found;
		logic [POS_W-1:0]  found_index;
		logic [FILL_W-1:0] fill_count;
	} out_item_t;

	// Port request into the entry store.
	typedef struct packed {
		logic                     we;
		logic [IDX_W-1:0]         waddr;
		logic signed [DATA_W-1:0] wdata;
		logic [IDX_W-1:0]         raddr;
	} mem_req_t;

	// Sequencer status towards the top level.
	typedef struct packed {
		logic busy;
		logic done;
	} seq_stat_t;

	// Zero-extends an unsigned working value to comparator width.
	function automatic logic signed [CW-1:0] zx(input logic [WW-1:0] v);
		return $signed(CW'(v));
	endfunction

	// Sign-extends a search bound to comparator width.
	function automatic logic signed [CW-1:0] sx(input logic signed [SW-1:0] v);
		return {{(CW-SW){v[SW-1]}}, v};
	endfunction

endpackage

// ===== sv/oaids_store.sv =====
module oaids_store (
	input  logic                                clk,
	input  oaids_pkg::mem_req_t                 req,
	output logic signed [oaids_pkg::DATA_W-1:0] rdata
);

	logic signed [oaids_pkg::DATA_W-1:0] store_q [oaids_pkg::DEPTH];
	logic signed [oaids_pkg::DATA_W-1:0] rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (req.we) begin
			store_q[req.waddr] <= req.wdata;
		end
		rdata_q <= store_q[req.raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/oaids_cmp.sv =====
module oaids_cmp (
	input  logic signed [oaids_pkg::CW-1:0] a,
	input  logic signed [oaids_pkg::CW-1:0] b,
	output logic                            lt,
	output logic                            eq
);

	// Signed compare shared by the checks, shift loops and search steps of the sequencer.
	assign lt = (a < b);
	assign eq = (a == b);

endmodule

// ===== sv/oaids_seq.sv =====
module oaids_seq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  oaids_pkg::in_item_t                 cmd,
	input  logic [oaids_pkg::WW-1:0]            limit,
	input  logic                                res_take,
	input  logic signed [oaids_pkg::DATA_W-1:0] rdata,
	output oaids_pkg::mem_req_t                 req,
	output oaids_pkg::seq_stat_t                stat,
	output oaids_pkg::out_item_t                res
);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_CHK1  = 9'b000000010,
		S_CHK2  = 9'b000000100,
		S_INS   = 9'b000001000,
		S_PUT   = 9'b000010000,
		S_DEL   = 9'b000100000,
		S_SRCH  = 9'b001000000,
		S_PROBE = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	state_t                               state_q;
	oaids_pkg::in_item_t                  cmd_q;
	logic [oaids_pkg::CNT_W-1:0]          count_q;
	logic [oaids_pkg::WW-1:0]             ptr_q;
	logic                                 pend_q;
	logic [oaids_pkg::IDX_W-1:0]          pend_addr_q;
	logic signed [oaids_pkg::SW-1:0]      lo_q;
	logic signed [oaids_pkg::SW-1:0]      hi_q;
	logic signed [oaids_pkg::SW-1:0]      mid_q;
	logic [oaids_pkg::STAT_W-1:0]         status_q;
	logic                                 found_q;
	logic [oaids_pkg::POS_W-1:0]          fidx_q;

	logic [oaids_pkg::WW-1:0]             count_w;
	logic [oaids_pkg::WW-1:0]             pos_w;
	logic [oaids_pkg::WW-1:0]             ptr_inc;
	logic [oaids_pkg::WW-1:0]             ptr_dec;
	logic signed [oaids_pkg::SW:0]        mid_sum;
	logic signed [oaids_pkg::SW-1:0]      mid;
	logic signed [oaids_pkg::SW-1:0]      top_idx;
	logic signed [oaids_pkg::CW-1:0]      cmp_a;
	logic signed [oaids_pkg::CW-1:0]      cmp_b;
	logic                                 cmp_lt;
	logic                                 cmp_eq;

	// Index arithmetic around the loop pointers and search bounds.
	assign count_w = oaids_pkg::WW'(count_q);
	assign pos_w   = oaids_pkg::WW'(cmd_q.position);
	assign ptr_inc = ptr_q + 1'b1;
	assign ptr_dec = ptr_q - 1'b1;
	assign mid_sum = {lo_q[oaids_pkg::SW-1], lo_q} + {hi_q[oaids_pkg::SW-1], hi_q};
	assign mid     = mid_sum[oaids_pkg::SW:1];
	assign top_idx = $signed(oaids_pkg::SW'(count_q)) - 2'sd1;

	// Operand selection for the shared comparator, one question per state.
	always_comb begin
		cmp_a = '0;
		cmp_b = '0;
		case (state_q)
			S_CHK1: begin
				case (cmd_q.mode)
					oaids_pkg::MODE_INSERT: begin
						cmp_a = oaids_pkg::zx(count_w);
						cmp_b = oaids_pkg::zx(limit);
					end
					oaids_pkg::MODE_DELETE: begin
						cmp_a = oaids_pkg::zx(pos_w);
						cmp_b = oaids_pkg::zx(count_w);
					end
					oaids_pkg::MODE_SEARCH: begin
						cmp_a = oaids_pkg::zx(oaids_pkg::WW'(cmd_q.range_high));
						cmp_b = oaids_pkg::zx(count_w);
					end
					default: begin
						cmp_a = '0;
						cmp_b = '0;
					end
				endcase
			end
			S_CHK2: begin
				cmp_a = oaids_pkg::zx(count_w);
				cmp_b = oaids_pkg::zx(pos_w);
			end
			S_INS: begin
				cmp_a = oaids_pkg::zx(pos_w);
				cmp_b = oaids_pkg::zx(ptr_q);
			end
			S_DEL: begin
				cmp_a = oaids_pkg::zx(ptr_inc);
				cmp_b = oaids_pkg::zx(count_w);
			end
			S_SRCH: begin
				cmp_a = oaids_pkg::sx(hi_q);
				cmp_b = oaids_pkg::sx(lo_q);
			end
			S_PROBE: begin
				cmp_a = {cmd_q.item_value[oaids_pkg::DATA_W-1], cmd_q.item_value};
				cmp_b = {rdata[oaids_pkg::DATA_W-1], rdata};
			end
			default: begin
				cmp_a = '0;
				cmp_b = '0;
			end
		endcase
	end

	oaids_cmp u_cmp (
		.a  (cmp_a),
		.b  (cmp_b),
		.lt (cmp_lt),
		.eq (cmp_eq)
	);

	// Store port: a shift moves one entry a cycle, read one step ahead of the write.
	always_comb begin
		req.we    = 1'b0;
		req.waddr = pend_addr_q;
		req.wdata = rdata;
		req.raddr = '0;
		case (state_q)
			S_INS: begin
				req.we = pend_q;
				if (cmp_lt) begin
					req.raddr = oaids_pkg::IDX_W'(ptr_dec);
				end
			end
			S_PUT: begin
				req.we    = 1'b1;
				req.waddr = oaids_pkg::IDX_W'(pos_w);
				req.wdata = cmd_q.item_value;
			end
			S_DEL: begin
				req.we = pend_q;
				if (cmp_lt) begin
					req.raddr = oaids_pkg::IDX_W'(ptr_inc);
				end
			end
			S_SRCH: begin
				req.raddr = oaids_pkg::IDX_W'(mid);
			end
			default: begin
				req.we = 1'b0;
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= '0;
			count_q     <= '0;
			ptr_q       <= '0;
			pend_q      <= 1'b0;
			pend_addr_q <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			mid_q       <= '0;
			status_q    <= oaids_pkg::STAT_OK;
			found_q     <= 1'b0;
			fidx_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q    <= cmd;
						status_q <= oaids_pkg::STAT_OK;
						found_q  <= 1'b0;
						fidx_q   <= '0;
						state_q  <= S_CHK1;
					end
				end
				S_CHK1: begin
					case (cmd_q.mode)
						oaids_pkg::MODE_INSERT: begin
							if (!cmp_lt) begin
								status_q <= oaids_pkg::STAT_FULL;
								state_q  <= S_DONE;
							end else begin
								state_q <= S_CHK2;
							end
						end
						oaids_pkg::MODE_DELETE: begin
							if (!cmp_lt) begin
								status_q <= oaids_pkg::STAT_RANGE;
								state_q  <= S_DONE;
							end else begin
								ptr_q   <= pos_w;
								pend_q  <= 1'b0;
								state_q <= S_DEL;
							end
						end
						oaids_pkg::MODE_SEARCH: begin
							lo_q    <= $signed(oaids_pkg::SW'(cmd_q.range_low));
							hi_q    <= cmp_lt ? $signed(oaids_pkg::SW'(cmd_q.range_high))
								: top_idx;
							state_q <= S_SRCH;
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_CHK2: begin
					if (cmp_lt) begin
						status_q <= oaids_pkg::STAT_RANGE;
						state_q  <= S_DONE;
					end else begin
						ptr_q   <= count_w;
						pend_q  <= 1'b0;
						state_q <= S_INS;
					end
				end
				S_INS: begin
					if (cmp_lt) begin
						pend_q      <= 1'b1;
						pend_addr_q <= oaids_pkg::IDX_W'(ptr_q);
						ptr_q       <= ptr_dec;
					end else begin
						pend_q  <= 1'b0;
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					count_q <= count_q + 1'b1;
					state_q <= S_DONE;
				end
				S_DEL: begin
					if (cmp_lt) begin
						pend_q      <= 1'b1;
						pend_addr_q <= oaids_pkg::IDX_W'(ptr_q);
						ptr_q       <= ptr_inc;
					end else begin
						pend_q  <= 1'b0;
						count_q <= count_q - 1'b1;
						state_q <= S_DONE;
					end
				end
				S_SRCH: begin
					if (cmp_lt) begin
						state_q <= S_DONE;
					end else begin
						mid_q   <= mid;
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (cmp_eq) begin
						found_q <= 1'b1;
						fidx_q  <= mid_q[oaids_pkg::POS_W-1:0];
						state_q <= S_DONE;
					end else begin
						if (!cmp_lt) begin
							lo_q <= mid_q + 2'sd1;
						end else begin
							hi_q <= mid_q - 2'sd1;
						end
						state_q <= S_SRCH;
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result and status towards the output register.
	assign stat.busy       = (state_q != S_IDLE);
	assign stat.done       = (state_q == S_DONE) && res_take;
	assign res.status      = status_q;
	assign res.found       = found_q;
	assign res.found_index = fidx_q;
	assign res.fill_count  = oaids_pkg::FILL_W'(count_q);

endmodule

// ===== sv/ordered_array_insert_delete_search_unit.sv =====
// Ordered array store with insert, delete and binary search.
// Input channel (in_valid, in_stall, in_data): one beat is one operation, taken at
// a clock edge with in_valid high and in_stall low. in_stall stays high while an
// operation is in progress, so one operation is worked on at a time.
// Output channel (out_valid, out_stall, out_data): exactly one result beat per
// operation, held in an output register until taken with out_stall low.
// Per operation: insert and delete shift the entries behind the position at one
// entry per cycle; insert checks for a full store before it checks the position;
// a search makes at most log2(DEPTH) + 1 probes.
// The next beat is accepted at the earliest in the cycle after the result is loaded.
// The shifts run at one entry per cycle through the single write port and the
// registered read port of the entry store; each search probe waits on that read.
// Configuration: cfg_we and cfg_data write the capacity; only while idle.
// Reset clears the fill count and the output valid and sets capacity to 256;
// the store contents are left as they are. If the receiver stalls, the finished
// result waits in the output register, a further operation may be accepted, and
// its result waits inside the sequencer until the register is free.
module ordered_array_insert_delete_search_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  oaids_pkg::in_item_t            in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output oaids_pkg::out_item_t           out_data,
	input  logic                           cfg_we,
	input  logic [oaids_pkg::CAP_W-1:0]    cfg_data
);

	logic [oaids_pkg::CAP_W-1:0]         capacity_q;
	logic                                out_valid_q;
	oaids_pkg::out_item_t                out_q;

	logic [oaids_pkg::WW-1:0]            cap_w;
	logic [oaids_pkg::WW-1:0]            depth_w;
	logic [oaids_pkg::WW-1:0]            limit;
	logic                                start;
	logic                                res_take;
	oaids_pkg::seq_stat_t                stat;
	oaids_pkg::out_item_t                res;
	oaids_pkg::mem_req_t                 req;
	logic signed [oaids_pkg::DATA_W-1:0] rdata;

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= oaids_pkg::CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_data;
		end
	end

	// Usable limit is the smaller of capacity and built depth.
	assign cap_w   = oaids_pkg::WW'(capacity_q);
	assign depth_w = oaids_pkg::WW'(oaids_pkg::DEPTH);
	assign limit   = (cap_w < depth_w) ? cap_w : depth_w;

	// Input handshake.
	assign in_stall = stat.busy;
	assign start    = in_valid && !in_stall;

	// The output register may be loaded when empty or when its beat leaves now.
	assign res_take = !out_valid_q || !out_stall;

	oaids_store u_store (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	oaids_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cmd      (in_data),
		.limit    (limit),
		.res_take (res_take),
		.rdata    (rdata),
		.req      (req),
		.stat     (stat),
		.res      (res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (stat.done) begin
			out_valid_q <= 1'b1;
			out_q       <= res;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== sv/oaids_chk.sv =====
module oaids_chk (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input oaids_pkg::out_item_t out_data
);

	// A held result beat does not change while stalled.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// An accepted operation keeps the input side stalled in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after an accepted operation");

	// A located value only comes with an ok status.
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.found |-> out_data.status == oaids_pkg::STAT_OK)
		else $error("found with an error status");

	// No index is reported without a hit.
	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.found |-> out_data.found_index == '0)
		else $error("index reported without a hit");

	// The fill count never exceeds the built depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.fill_count <= oaids_pkg::FILL_W'(oaids_pkg::DEPTH))
		else $error("fill count beyond depth");

endmodule

bind ordered_array_insert_delete_search_unit oaids_chk u_oaids_chk (.*);

// ===== dv/ordered_array_insert_delete_search_unit_test.sv =====
`timescale 1ns / 100ps

module ordered_array_insert_delete_search_unit_test;
	import oaids_pkg::*;

	// Mode code that the block does not use; it must leave the store alone.
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int TARGET_OPS = 1800;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [CAP_W-1:0] cfg_data = '0;

	// Operations waiting to be driven, and results still owed by the block.
	in_item_t queued_ops[$];
	out_item_t awaited_outcomes[$];

	// Shadow copy of the store, used to work out each result.
	logic signed [DATA_W-1:0] shadow_entries[0:DEPTH-1];
	int shadow_count = 0;
	int shadow_capacity = 256;

	// Stimulus-side view of the contents, used to pick meaningful operations.
	logic signed [DATA_W-1:0] planned_entries[$];
	int planned_limit = 256;

	logic in_fire = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	int hold_left = 0;
	int free_left = 0;
	int issued_ops = 0;
	int checked_results = 0;
	int fail_count = 0;
	int capacity_writes = 0;
	int ops_by_mode[4] = '{0, 0, 0, 0};
	int search_hits = 0;
	int refusals = 0;

	ordered_array_insert_delete_search_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Applies one operation to the shadow store and returns the result it should give.
	function automatic out_item_t array_op_outcome(input in_item_t op);
		out_item_t res;
		int limit;
		int pos;
		int lo;
		int hi;
		int mid;
		int i;
		logic signed [DATA_W-1:0] key;
		res = '0;
		key = op.item_value;
		pos = int'(op.position);
		limit = (shadow_capacity < DEPTH) ? shadow_capacity : DEPTH;
		case (op.mode)
			MODE_INSERT: begin
				if (shadow_count >= limit) begin
					res.status = STAT_FULL;
				end else if (pos > shadow_count) begin
					res.status = STAT_RANGE;
				end else begin
					for (i = shadow_count; i > pos; i--)
						shadow_entries[i] = shadow_entries[i - 1];
					shadow_entries[pos] = key;
					shadow_count++;
				end
			end
			MODE_DELETE: begin
				if (pos >= shadow_count) begin
					res.status = STAT_RANGE;
				end else begin
					for (i = pos; i + 1 < shadow_count; i++)
						shadow_entries[i] = shadow_entries[i + 1];
					shadow_count--;
					shadow_entries[shadow_count] = '0;
				end
			end
			MODE_SEARCH: begin
				// The upper bound is clipped to the last filled entry.
				lo = int'(op.range_low);
				hi = int'(op.range_high);
				if (hi > shadow_count - 1)
					hi = shadow_count - 1;
				while (lo <= hi) begin
					mid = (lo + hi) / 2;
					if (shadow_entries[mid] == key) begin
						res.found = 1'b1;
						res.found_index = POS_W'(mid);
						break;
					end
					if (key > shadow_entries[mid])
						lo = mid + 1;
					else
						hi = mid - 1;
				end
			end
			default: begin
			end
		endcase
		res.fill_count = FILL_W'(shadow_count);
		return res;
	endfunction

	// Queues one operation and keeps the planned contents in step with it.
	task automatic push_op(input logic [MODE_W-1:0] m, input int pos,
			input logic signed [DATA_W-1:0] val, input int lo, input int hi);
		in_item_t op;
		op.mode = m;
		op.position = POS_W'(pos);
		op.item_value = val;
		op.range_low = POS_W'(lo);
		op.range_high = POS_W'(hi);
		queued_ops.push_back(op);
		if (m == MODE_INSERT && planned_entries.size() < planned_limit &&
				pos <= planned_entries.size())
			planned_entries.insert(pos, val);
		else if (m == MODE_DELETE && pos < planned_entries.size())
			planned_entries.delete(pos);
		issued_ops++;
	endtask

	// Mostly ordered inserts, deletes of held entries and searches for held
	// values; the rest is noise with positions and ranges anywhere.
	task automatic make_random_op(input int ins_pct, input int del_pct);
		int roll;
		int cnt;
		int pos;
		int lo;
		int hi;
		logic signed [DATA_W-1:0] val;
		roll = $urandom_range(0, 99);
		cnt = planned_entries.size();
		case ($urandom_range(0, 5))
			0, 1: val = $urandom;
			2: val = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: val = $signed($urandom_range(0, 200)) - 100;
		endcase
		lo = $urandom_range(0, 255);
		hi = $urandom_range(0, 255);
		if (roll < ins_pct) begin
			case ($urandom_range(0, 9))
				0: pos = $urandom_range(0, 255);
				1: pos = cnt;
				default: begin
					pos = 0;
					while (pos < cnt && planned_entries[pos] < val)
						pos++;
				end
			endcase
			push_op(MODE_INSERT, pos, val, lo, hi);
		end else if (roll < ins_pct + del_pct) begin
			if (cnt > 0 && $urandom_range(0, 7) != 0)
				pos = $urandom_range(0, cnt - 1);
			else
				pos = $urandom_range(0, 255);
			push_op(MODE_DELETE, pos, val, lo, hi);
		end else if (roll < 96) begin
			if (cnt > 0 && $urandom_range(0, 9) < 6)
				val = planned_entries[$urandom_range(0, cnt - 1)];
			case ($urandom_range(0, 3))
				0, 1: begin
					lo = 0;
					hi = 255;
				end
				2: begin
					lo = $urandom_range(0, cnt > 255 ? 255 : cnt);
					hi = $urandom_range(lo, 255);
				end
				default: begin
				end
			endcase
			push_op(MODE_SEARCH, $urandom_range(0, 255), val, lo, hi);
		end else begin
			push_op(MODE_UNUSED, $urandom_range(0, 255), val, lo, hi);
		end
	endtask

	// Waits until every queued beat has been taken and every result has come back.
	task automatic wait_drained();
		while (queued_ops.size() != 0 || in_valid || awaited_outcomes.size() != 0)
			@(negedge clk);
	endtask

	// Capacity is only written with the block idle.
	task automatic set_capacity(input int cap);
		wait_drained();
		repeat (4) @(negedge clk);
		cfg_we = 1'b1;
		cfg_data = CAP_W'(cap);
		@(negedge clk);
		cfg_we = 1'b0;
		planned_limit = (cap < DEPTH) ? cap : DEPTH;
		capacity_writes++;
	endtask

	// Sender: bursts of beats with random gaps; a stalled beat is held as it is.
	always @(negedge clk) begin : sender
		in_item_t next_beat;
		if (arst_n && !(in_valid && !in_fire)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (queued_ops.size() > 0) begin
				next_beat = queued_ops.pop_front();
				in_data <= next_beat;
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: stalls in short runs, with the odd long stretch free of stalls.
	always @(negedge clk) begin : receiver
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (free_left > 0) begin
				free_left--;
				out_stall <= 1'b0;
			end else begin
				free_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 6);
				hold_left = $urandom_range(0, 5);
				out_stall <= 1'b0;
			end
		end
	end

	// Monitor: predicts on each accepted input beat, checks each accepted result beat.
	always @(posedge clk) begin : monitor
		out_item_t want;
		out_item_t got;
		if (arst_n) begin
			in_fire <= in_valid && !in_stall;
			if (cfg_we)
				shadow_capacity = int'(cfg_data);
			if (out_valid && !out_stall) begin
				got = out_data;
				if (awaited_outcomes.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result beat: status %0d found %0d index %0d fill %0d",
							got.status, got.found, got.found_index, got.fill_count);
					fail_count++;
				end else begin
					want = awaited_outcomes.pop_front();
					checked_results++;
					if (got.status !== want.status || got.found !== want.found ||
							got.found_index !== want.found_index ||
							got.fill_count !== want.fill_count) begin
						if (fail_count < 10) begin
							$display("result %0d mismatch (expected/actual): status %0d/%0d found %0d/%0d",
								checked_results, want.status, got.status, want.found, got.found);
							$display("  index %0d/%0d fill %0d/%0d",
								want.found_index, got.found_index, want.fill_count,
								got.fill_count);
						end
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				want = array_op_outcome(in_data);
				ops_by_mode[in_data.mode]++;
				if (want.found)
					search_hits++;
				if (want.status != STAT_OK)
					refusals++;
				awaited_outcomes.push_back(want);
			end
		end
	end

	initial begin : stimulus
		int cap;
		int phase_no;
		int i;
		for (i = 0; i < DEPTH; i++)
			shadow_entries[i] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part at the reset capacity, starting from an empty store.
		push_op(MODE_SEARCH, 0, 0, 0, 255);
		push_op(MODE_DELETE, 0, 0, 0, 0);
		push_op(MODE_INSERT, 1, 5, 0, 0);
		push_op(MODE_INSERT, 0, 32'sh80000000, 0, 0);
		push_op(MODE_INSERT, 1, 32'sh7fffffff, 0, 0);
		push_op(MODE_INSERT, 1, 0, 255, 255);
		push_op(MODE_SEARCH, 255, 0, 0, 255);
		push_op(MODE_SEARCH, 0, 32'sh80000000, 0, 255);
		push_op(MODE_SEARCH, 0, 32'sh7fffffff, 0, 255);
		push_op(MODE_SEARCH, 0, 7, 0, 255);
		push_op(MODE_SEARCH, 0, 32'sh7fffffff, 255, 255);
		push_op(MODE_SEARCH, 0, 0, 2, 0);
		push_op(MODE_UNUSED, 255, 32'shffffffff, 255, 255);
		push_op(MODE_INSERT, 255, 1, 0, 0);
		push_op(MODE_DELETE, 255, 0, 0, 0);
		// An entry out of order: the search may miss a value that is held.
		push_op(MODE_INSERT, 0, 9, 0, 0);
		push_op(MODE_SEARCH, 0, 32'sh7fffffff, 0, 255);
		push_op(MODE_SEARCH, 0, 9, 0, 255);
		push_op(MODE_DELETE, 0, 0, 0, 0);
		push_op(MODE_DELETE, 2, 0, 0, 0);
		push_op(MODE_INSERT, 2, 32'sh55555555, 0, 0);
		// Capacity zero refuses every insert as full, before the index is looked at.
		set_capacity(0);
		push_op(MODE_INSERT, 255, 3, 0, 0);
		push_op(MODE_INSERT, 0, 3, 0, 0);
		// Capacity below the count: inserts refused, deletes and searches still work.
		set_capacity(1);
		push_op(MODE_INSERT, 1, 3, 0, 0);
		push_op(MODE_SEARCH, 0, 32'sh55555555, 0, 255);
		push_op(MODE_DELETE, 0, 0, 0, 0);

		// Random phases, each under a capacity of its own; one fills the whole
		// store and the next drains it again under a small capacity.
		phase_no = 0;
		while (issued_ops < TARGET_OPS) begin
			phase_no++;
			if (phase_no == 3) begin
				set_capacity(511);
				repeat (320) make_random_op(85, 5);
			end else if (phase_no == 4) begin
				set_capacity($urandom_range(1, 16));
				repeat (300) make_random_op(5, 80);
			end else begin
				case ($urandom_range(0, 7))
					0: cap = 0;
					1: cap = 1;
					2: cap = 256;
					3: cap = 511;
					4, 5: cap = $urandom_range(2, 12);
					default: cap = $urandom_range(13, 48);
				endcase
				set_capacity(cap);
				repeat ($urandom_range(60, 150)) make_random_op(40, 25);
			end
		end

		// Let the last results arrive, then watch a little longer for strays.
		wait_drained();
		repeat (300) @(negedge clk);
		if (awaited_outcomes.size() != 0) begin
			$display("%0d results never arrived", awaited_outcomes.size());
			fail_count++;
		end
		$display("Ran %0d operations (%0d inserts, %0d deletes, %0d searches, %0d unused mode)",
			issued_ops, ops_by_mode[MODE_INSERT], ops_by_mode[MODE_DELETE],
			ops_by_mode[MODE_SEARCH], ops_by_mode[MODE_UNUSED]);
		$display("Checked %0d results: %0d search hits, %0d refused, %0d capacity settings",
			checked_results, search_hits, refusals, capacity_writes);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Worst case is about 2200 beats, as the last phase may overshoot, each at most a
	// full-store shift plus its checks; allow six times that.
	initial begin : watchdog
		#40_000_000;
		$display("timeout with %0d results outstanding", awaited_outcomes.size());
		$display("TB_ERROR");
		$finish;
	end

endmodule
